// File: hw/rtl/qftv_pkg.sv
// ----------------------------------------------------------------------------
// qftv_pkg
// Types and constants shared by the shortest-arc quaternion datapath.
// ----------------------------------------------------------------------------
package qftv_pkg;

    // Width of each input component on the port
    localparam int COMPONENT_BITS = 16;
    // Internal working width of each component
    localparam int CORE_BITS      = 16;

    localparam logic [5:0] SHIFT_RESET = 6'd20;

    // Integer square root of a 64-bit value yields 32 result bits
    localparam int SQRT_STEPS = 32;
    // Normalized quotient never exceeds 32768, so 17 bits
    localparam int QUOT_BITS  = 17;
    // Largest magnitude is normalized so its top bit sits here
    localparam int NORM_MSB   = 30;

    localparam logic [16:0] Q_POS_MAX = 17'd32767;
    localparam logic [16:0] Q_NEG_MAX = 17'd32768;

    typedef struct packed {
        logic signed [COMPONENT_BITS-1:0] ux;
        logic signed [COMPONENT_BITS-1:0] uy;
        logic signed [COMPONENT_BITS-1:0] uz;
        logic signed [COMPONENT_BITS-1:0] vx;
        logic signed [COMPONENT_BITS-1:0] vy;
        logic signed [COMPONENT_BITS-1:0] vz;
    } t_item_in;

    typedef struct packed {
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
        logic               degenerate;
    } t_item_out;

    // Carried alongside the first square root
    typedef struct packed {
        logic signed [33:0] d;
        logic signed [32:0] cx;
        logic signed [32:0] cy;
        logic signed [32:0] cz;
        logic signed [15:0] ux;
        logic signed [15:0] uy;
        logic signed [15:0] uz;
    } t_arc_side;

    // Carried alongside the second square root and the dividers
    typedef struct packed {
        logic [3:0][30:0] mag;
        logic [3:0]       neg;
        logic             deg;
    } t_norm_side;

endpackage

// File: hw/rtl/quaternion_from_two_vectors_unit.sv
// ----------------------------------------------------------------------------
// quaternion_from_two_vectors_unit
// Shortest-arc unit quaternion from two fixed-point 3-vectors, Q1.15 out.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// The two 32-step square roots and the 17-step dividers set the depth.
// Reset clears all valid bits and loads the threshold shift with 20.
// The receiver cannot stall: o_valid marks each result for one cycle.
module quaternion_from_two_vectors_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  qftv_pkg::t_item_in   i_item,
    output logic                 o_valid,
    output qftv_pkg::t_item_out  o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [5:0]           i_cfg_data
);

    localparam int InShift = (qftv_pkg::COMPONENT_BITS > qftv_pkg::CORE_BITS) ?
                             (qftv_pkg::COMPONENT_BITS - qftv_pkg::CORE_BITS) : 0;
    localparam int Sq = qftv_pkg::SQRT_STEPS;
    localparam int Qb = qftv_pkg::QUOT_BITS;

    logic [5:0] r_shift;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= qftv_pkg::SHIFT_RESET;
        end else if (i_cfg_valid) begin
            r_shift <= i_cfg_data;
        end
    end

    // ---------------- stage 0: capture, reduce to core width ----------------
    logic               r_v0;
    logic signed [15:0] r_u0 [0:2];
    logic signed [15:0] r_w0 [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u0[0] <= 16'(i_item.ux >>> InShift);
        r_u0[1] <= 16'(i_item.uy >>> InShift);
        r_u0[2] <= 16'(i_item.uz >>> InShift);
        r_w0[0] <= 16'(i_item.vx >>> InShift);
        r_w0[1] <= 16'(i_item.vy >>> InShift);
        r_w0[2] <= 16'(i_item.vz >>> InShift);
    end

    // ---------------- stage 1: products ----------------
    logic               r_v1;
    logic [30:0]        r_squ [0:2];
    logic [30:0]        r_sqv [0:2];
    logic signed [31:0] r_dp  [0:2];
    logic signed [31:0] r_cp  [0:5];
    logic signed [15:0] r_u1  [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_squ[i] <= 31'(unsigned'(32'(r_u0[i] * r_u0[i])));
            r_sqv[i] <= 31'(unsigned'(32'(r_w0[i] * r_w0[i])));
            r_dp[i]  <= 32'(r_u0[i] * r_w0[i]);
            r_u1[i]  <= r_u0[i];
        end
        r_cp[0] <= 32'(r_u0[1] * r_w0[2]);
        r_cp[1] <= 32'(r_w0[1] * r_u0[2]);
        r_cp[2] <= 32'(r_w0[0] * r_u0[2]);
        r_cp[3] <= 32'(r_u0[0] * r_w0[2]);
        r_cp[4] <= 32'(r_u0[0] * r_w0[1]);
        r_cp[5] <= 32'(r_w0[0] * r_u0[1]);
    end

    // ---------------- stage 2: sums ----------------
    logic                r_v2;
    logic [31:0]         r_uu;
    logic [31:0]         r_vv;
    qftv_pkg::t_arc_side r_side2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_uu <= 32'(r_squ[0]) + 32'(r_squ[1]) + 32'(r_squ[2]);
        r_vv <= 32'(r_sqv[0]) + 32'(r_sqv[1]) + 32'(r_sqv[2]);
        r_side2.d  <= 34'(r_dp[0]) + 34'(r_dp[1]) + 34'(r_dp[2]);
        r_side2.cx <= 33'(r_cp[0]) - 33'(r_cp[1]);
        r_side2.cy <= 33'(r_cp[2]) - 33'(r_cp[3]);
        r_side2.cz <= 33'(r_cp[4]) - 33'(r_cp[5]);
        r_side2.ux <= r_u1[0];
        r_side2.uy <= r_u1[1];
        r_side2.uz <= r_u1[2];
    end

    // ---------------- stage 3: norm product, then square root ----------------
    logic                r_a_vld  [0:Sq];
    logic [63:0]         r_a_rem  [0:Sq];
    logic [31:0]         r_a_res  [0:Sq];
    qftv_pkg::t_arc_side r_a_side [0:Sq];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld[0] <= 1'b0;
        end else begin
            r_a_vld[0] <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_rem[0]  <= r_uu * r_vv;
        r_a_res[0]  <= '0;
        r_a_side[0] <= r_side2;
    end

    // One result bit per stage, most significant first
    for (genvar j = 0; j < Sq; j++) begin : g_sqrt_a
        localparam int B = Sq - 1 - j;
        logic [65:0] n_trial;
        assign n_trial = (66'(r_a_res[j]) << (B + 1)) + (66'd1 << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_vld[j+1] <= 1'b0;
            end else begin
                r_a_vld[j+1] <= r_a_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_a_side[j+1] <= r_a_side[j];
            if (66'(r_a_rem[j]) >= n_trial) begin
                r_a_rem[j+1] <= 64'(66'(r_a_rem[j]) - n_trial);
                r_a_res[j+1] <= r_a_res[j] | (32'd1 << B);
            end else begin
                r_a_rem[j+1] <= r_a_rem[j];
                r_a_res[j+1] <= r_a_res[j];
            end
        end
    end

    // ---------------- stage 4: real part, opposite test, raw quaternion ----------------
    qftv_pkg::t_arc_side n_sd;
    logic [31:0]         n_nn;
    logic signed [34:0]  n_r;
    logic [31:0]         n_lim;
    logic                n_opp;
    logic [16:0]         n_ax;
    logic [16:0]         n_az;

    assign n_sd  = r_a_side[Sq];
    assign n_nn  = r_a_res[Sq];
    assign n_r   = 35'(n_nn) + 35'(n_sd.d);
    assign n_lim = (n_nn - 32'd1) >> r_shift;
    assign n_ax  = n_sd.ux[15] ? 17'(-18'(n_sd.ux)) : 17'(n_sd.ux);
    assign n_az  = n_sd.uz[15] ? 17'(-18'(n_sd.uz)) : 17'(n_sd.uz);

    always_comb begin
        if (n_r[34]) begin
            n_opp = 1'b1;
        end else if (n_nn == '0) begin
            n_opp = 1'b0;
        end else begin
            n_opp = (34'(n_r) <= 34'(n_lim));
        end
    end

    logic               r_v4;
    logic signed [34:0] r_q4 [0:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_a_vld[Sq];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_opp) begin
            r_q4[3] <= '0;
            if (n_ax > n_az) begin
                r_q4[0] <= -35'(n_sd.uy);
                r_q4[1] <= 35'(n_sd.ux);
                r_q4[2] <= '0;
            end else begin
                r_q4[0] <= '0;
                r_q4[1] <= -35'(n_sd.uz);
                r_q4[2] <= 35'(n_sd.uy);
            end
        end else begin
            r_q4[0] <= 35'(n_sd.cx);
            r_q4[1] <= 35'(n_sd.cy);
            r_q4[2] <= 35'(n_sd.cz);
            r_q4[3] <= n_r;
        end
    end

    // ---------------- stage 5: magnitudes ----------------
    logic        r_v5;
    logic [33:0] r_m5 [0:3];
    logic [3:0]  r_neg5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_neg5[i] <= r_q4[i][34];
            r_m5[i]   <= r_q4[i][34] ? 34'(-r_q4[i]) : 34'(r_q4[i]);
        end
    end

    // ---------------- stage 6: largest magnitude ----------------
    logic        r_v6;
    logic [33:0] r_m6 [0:3];
    logic [3:0]  r_neg6;
    logic [33:0] r_mx6;
    logic [33:0] n_mx01;
    logic [33:0] n_mx23;

    assign n_mx01 = (r_m5[0] > r_m5[1]) ? r_m5[0] : r_m5[1];
    assign n_mx23 = (r_m5[2] > r_m5[3]) ? r_m5[2] : r_m5[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else begin
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m6   <= r_m5;
        r_neg6 <= r_neg5;
        r_mx6  <= (n_mx01 > n_mx23) ? n_mx01 : n_mx23;
    end

    // ---------------- stage 7: normalizing shift amount ----------------
    logic [5:0] n_msb;

    always_comb begin
        n_msb = '0;
        for (int i = 0; i < 34; i++) begin
            if (r_mx6[i]) begin
                n_msb = 6'(i);
            end
        end
    end

    logic        r_v7;
    logic [33:0] r_m7 [0:3];
    logic [3:0]  r_neg7;
    logic        r_deg7;
    logic [4:0]  r_up7;
    logic [1:0]  r_dn7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
        end else begin
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m7   <= r_m6;
        r_neg7 <= r_neg6;
        r_deg7 <= (r_mx6 == '0);
        if (n_msb > 6'(qftv_pkg::NORM_MSB)) begin
            r_up7 <= '0;
            r_dn7 <= 2'(n_msb - 6'(qftv_pkg::NORM_MSB));
        end else begin
            r_up7 <= 5'(6'(qftv_pkg::NORM_MSB) - n_msb);
            r_dn7 <= '0;
        end
    end

    // ---------------- stage 8: apply shift ----------------
    logic                 r_v8;
    qftv_pkg::t_norm_side r_sd8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v8 <= 1'b0;
        end else begin
            r_v8 <= r_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_sd8.mag[i] <= 31'((64'(r_m7[i]) << r_up7) >> r_dn7);
        end
        r_sd8.neg <= r_neg7;
        r_sd8.deg <= r_deg7;
    end

    // ---------------- stages 9 to 11: sum of squares ----------------
    logic                 r_v9;
    logic [61:0]          r_sq9 [0:3];
    qftv_pkg::t_norm_side r_sd9;
    logic                 r_v10;
    logic [62:0]          r_ps10 [0:1];
    qftv_pkg::t_norm_side r_sd10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v9  <= 1'b0;
            r_v10 <= 1'b0;
        end else begin
            r_v9  <= r_v8;
            r_v10 <= r_v9;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_sq9[i] <= 62'(r_sd8.mag[i]) * 62'(r_sd8.mag[i]);
        end
        r_sd9     <= r_sd8;
        r_ps10[0] <= 63'(r_sq9[0]) + 63'(r_sq9[1]);
        r_ps10[1] <= 63'(r_sq9[2]) + 63'(r_sq9[3]);
        r_sd10    <= r_sd9;
    end

    logic                 r_b_vld  [0:Sq];
    logic [63:0]          r_b_rem  [0:Sq];
    logic [31:0]          r_b_res  [0:Sq];
    qftv_pkg::t_norm_side r_b_side [0:Sq];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld[0] <= 1'b0;
        end else begin
            r_b_vld[0] <= r_v10;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_rem[0]  <= 64'(r_ps10[0]) + 64'(r_ps10[1]);
        r_b_res[0]  <= '0;
        r_b_side[0] <= r_sd10;
    end

    for (genvar j = 0; j < Sq; j++) begin : g_sqrt_b
        localparam int B = Sq - 1 - j;
        logic [65:0] n_trial;
        assign n_trial = (66'(r_b_res[j]) << (B + 1)) + (66'd1 << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_b_vld[j+1] <= 1'b0;
            end else begin
                r_b_vld[j+1] <= r_b_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_b_side[j+1] <= r_b_side[j];
            if (66'(r_b_rem[j]) >= n_trial) begin
                r_b_rem[j+1] <= 64'(66'(r_b_rem[j]) - n_trial);
                r_b_res[j+1] <= r_b_res[j] | (32'd1 << B);
            end else begin
                r_b_rem[j+1] <= r_b_rem[j];
                r_b_res[j+1] <= r_b_res[j];
            end
        end
    end

    // ---------------- dividers: one quotient bit per stage, four lanes ----------------
    logic        r_d_vld [0:Qb];
    logic [48:0] r_d_rem [0:Qb][0:3];
    logic [16:0] r_d_quo [0:Qb][0:3];
    logic [31:0] r_d_div [0:Qb];
    logic [3:0]  r_d_neg [0:Qb];
    logic        r_d_deg [0:Qb];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld[0] <= 1'b0;
        end else begin
            r_d_vld[0] <= r_b_vld[Sq];
        end
    end

    // Rounded numerator: 32768 * m + floor(root / 2)
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_d_rem[0][i] <= (49'(r_b_side[Sq].mag[i]) << 15) + 49'(r_b_res[Sq] >> 1);
            r_d_quo[0][i] <= '0;
        end
        r_d_div[0] <= r_b_res[Sq];
        r_d_neg[0] <= r_b_side[Sq].neg;
        r_d_deg[0] <= r_b_side[Sq].deg;
    end

    for (genvar j = 0; j < Qb; j++) begin : g_div
        localparam int B = Qb - 1 - j;
        logic [48:0] n_sub;
        assign n_sub = 49'(r_d_div[j]) << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_vld[j+1] <= 1'b0;
            end else begin
                r_d_vld[j+1] <= r_d_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_d_div[j+1] <= r_d_div[j];
            r_d_neg[j+1] <= r_d_neg[j];
            r_d_deg[j+1] <= r_d_deg[j];
            for (int i = 0; i < 4; i++) begin
                if (r_d_rem[j][i] >= n_sub) begin
                    r_d_rem[j+1][i] <= r_d_rem[j][i] - n_sub;
                    r_d_quo[j+1][i] <= r_d_quo[j][i] | (17'd1 << B);
                end else begin
                    r_d_rem[j+1][i] <= r_d_rem[j][i];
                    r_d_quo[j+1][i] <= r_d_quo[j][i];
                end
            end
        end
    end

    // ---------------- output: saturate and sign, zero if degenerate ----------------
    logic [15:0] n_q [0:3];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (r_d_deg[Qb]) begin
                n_q[i] = '0;
            end else if (r_d_neg[Qb][i]) begin
                n_q[i] = (r_d_quo[Qb][i] > qftv_pkg::Q_NEG_MAX) ?
                         16'(-qftv_pkg::Q_NEG_MAX) : 16'(-r_d_quo[Qb][i]);
            end else begin
                n_q[i] = (r_d_quo[Qb][i] > qftv_pkg::Q_POS_MAX) ?
                         16'(qftv_pkg::Q_POS_MAX) : 16'(r_d_quo[Qb][i]);
            end
        end
    end

    logic r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_d_vld[Qb];
        end
    end

    always_ff @(posedge i_clk) begin
        o_result.qx         <= n_q[0];
        o_result.qy         <= n_q[1];
        o_result.qz         <= n_q[2];
        o_result.qw         <= n_q[3];
        o_result.degenerate <= r_d_deg[Qb];
    end

    assign o_valid = r_out_vld;

endmodule

// File: tb/quaternion_from_two_vectors_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_from_two_vectors_unit_test
// Drives vector pairs into the shortest-arc quaternion unit, predicts each
// quaternion with an integer model of the datapath and compares every strobed
// result in order. Covers directed corner vectors and several threshold
// shifts, then long random runs with random gaps between items.
// ----------------------------------------------------------------------------
module quaternion_from_two_vectors_unit_test;

    localparam int LATENCY = 95;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    qftv_pkg::t_item_in   i_item = '0;
    logic                 o_valid;
    qftv_pkg::t_item_out  o_result;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [5:0]           i_cfg_data = '0;

    qftv_pkg::t_item_out  quat_queue[$];
    logic [5:0]           shift_model = qftv_pkg::SHIFT_RESET;
    int                   mismatch_count = 0;
    bit                   timed_out = 1'b0;

    quaternion_from_two_vectors_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_valid(o_valid), .o_result(o_result),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic qftv_pkg::t_item_out predict_quat(input qftv_pkg::t_item_in it);
        qftv_pkg::t_item_out q_out;
        logic signed [63:0] u[3];
        logic signed [63:0] v[3];
        logic signed [63:0] q[4];
        logic signed [63:0] d;
        logic signed [63:0] r;
        logic [63:0] uu, vv, nn, mx, s, root, k;
        logic [63:0] mag[4];
        bit          neg[4];
        bit          opposite;
        u[0] = 64'(it.ux); u[1] = 64'(it.uy); u[2] = 64'(it.uz);
        v[0] = 64'(it.vx); v[1] = 64'(it.vy); v[2] = 64'(it.vz);
        uu = 0; vv = 0; d = 0; mx = 0; s = 0;
        for (int i = 0; i < 3; i++) begin
            uu += u[i] * u[i];
            vv += v[i] * v[i];
            d += u[i] * v[i];
        end
        nn = isqrt(uu * vv);
        r = $signed(nn) + d;
        if (r < 0) opposite = 1;
        else if (nn == 0) opposite = 0;
        else opposite = r <= ((nn - 1) >> shift_model);
        if (opposite) begin
            if ((u[0] < 0 ? -u[0] : u[0]) > (u[2] < 0 ? -u[2] : u[2])) begin
                q[0] = -u[1]; q[1] = u[0]; q[2] = 0;
            end else begin
                q[0] = 0; q[1] = -u[2]; q[2] = u[1];
            end
            q[3] = 0;
        end else begin
            q[0] = u[1] * v[2] - v[1] * u[2];
            q[1] = v[0] * u[2] - u[0] * v[2];
            q[2] = u[0] * v[1] - v[0] * u[1];
            q[3] = r;
        end
        for (int i = 0; i < 4; i++) begin
            neg[i] = q[i] < 0;
            mag[i] = neg[i] ? -q[i] : q[i];
            if (mag[i] > mx) mx = mag[i];
        end
        q_out = '0;
        if (mx == 0) begin
            q_out.degenerate = 1'b1;
            return q_out;
        end
        while (mx >= (64'd1 << 31)) begin
            mx = mx >> 1;
            for (int i = 0; i < 4; i++) mag[i] = mag[i] >> 1;
        end
        while (mx < (64'd1 << 30)) begin
            mx = mx << 1;
            for (int i = 0; i < 4; i++) mag[i] = mag[i] << 1;
        end
        for (int i = 0; i < 4; i++) s += mag[i] * mag[i];
        root = isqrt(s);
        for (int i = 0; i < 4; i++) begin
            k = (64'd32768 * mag[i] + (root >> 1)) / root;
            if (neg[i]) begin
                if (k > 32768) k = 32768;
                k = -k;
            end else if (k > 32767) begin
                k = 32767;
            end
            q[i] = k;
        end
        q_out.qx = q[0][15:0];
        q_out.qy = q[1][15:0];
        q_out.qz = q[2][15:0];
        q_out.qw = q[3][15:0];
        return q_out;
    endfunction

    // Compare each strobed result against the oldest prediction
    always @(posedge i_clk) begin
        qftv_pkg::t_item_out exp_q;
        if (i_rst_n && o_valid) begin
            if (quat_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", o_result);
            end else begin
                exp_q = quat_queue.pop_front();
                if (o_result.qx !== exp_q.qx || o_result.qy !== exp_q.qy ||
                    o_result.qz !== exp_q.qz || o_result.qw !== exp_q.qw ||
                    o_result.degenerate !== exp_q.degenerate) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch exp q=(%0d %0d %0d %0d) deg=%0b got (%0d %0d %0d %0d) deg=%0b",
                            exp_q.qx, exp_q.qy, exp_q.qz, exp_q.qw, exp_q.degenerate,
                            o_result.qx, o_result.qy, o_result.qz, o_result.qw,
                            o_result.degenerate);
                end
            end
        end
    end

    // Hold start high across back-to-back items; drop it only for a gap
    task automatic send_item(input qftv_pkg::t_item_in it, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 14) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        quat_queue.push_back(predict_quat(it));
    endtask

    task automatic drain_pipeline;
        start <= 1'b0;
        while (quat_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_shift(input logic [5:0] value);
        drain_pipeline();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        shift_model = value;
    endtask

    function automatic qftv_pkg::t_item_in make_item(input int a, b, c, d, e, f);
        qftv_pkg::t_item_in it;
        it.ux = 16'(a); it.uy = 16'(b); it.uz = 16'(c);
        it.vx = 16'(d); it.vy = 16'(e); it.vz = 16'(f);
        return it;
    endfunction

    function automatic qftv_pkg::t_item_in random_item;
        qftv_pkg::t_item_in it;
        int sel;
        it = {$urandom, $urandom, $urandom};
        sel = $urandom_range(0, 9);
        // Steer some items toward opposite, parallel or small vectors
        if (sel < 2) begin
            it.vx = -it.ux; it.vy = -it.uy; it.vz = -it.uz;
            if (sel == 1) it.vx = it.vx + $signed(4'($urandom));
        end else if (sel == 2) begin
            it.vx = it.ux; it.vy = it.uy; it.vz = it.uz;
        end else if (sel == 3) begin
            it = make_item($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
                $urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
                $urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4);
        end
        return it;
    endfunction

    task automatic test_directed_corners;
        send_item(make_item(0, 0, 0, 0, 0, 0), 0);
        send_item(make_item(1, 0, 0, 0, 0, 0), 0);
        send_item(make_item(0, 0, 0, 0, 1, 0), 0);
        send_item(make_item(1, 0, 0, 1, 0, 0), 0);
        send_item(make_item(1, 0, 0, 0, 1, 0), 0);
        send_item(make_item(1, 0, 0, -1, 0, 0), 0);
        send_item(make_item(0, 1, 3, 0, -1, -3), 0);
        send_item(make_item(3, 1, 3, -3, -1, -3), 0);
        send_item(make_item(-32768, -32768, -32768, 32767, 32767, 32767), 0);
        send_item(make_item(-32768, -32768, -32768, -32768, -32768, -32768), 0);
        send_item(make_item(32767, 32767, 32767, -32768, -32768, -32768), 0);
        send_item(make_item(32767, -32768, 0, 0, 32767, -32768), 0);
        send_item(make_item(-32768, 0, 0, 0, 0, -32768), 0);
        send_item(make_item(0, 0, 32767, 0, 0, -32768), 0);
        send_item(make_item(1000, 0, 0, -1000, 1, 0), 0);
        send_item(make_item(-5, 7, 5, 5, -7, -5), 0);
    endtask

    task automatic test_shift_settings;
        logic [5:0] shifts[6] = '{6'd0, 6'd1, 6'd40, 6'd63, 6'd34, 6'd8};
        foreach (shifts[j]) begin
            write_shift(shifts[j]);
            send_item(make_item(1000, 0, 0, -1000, 1, 0), 0);
            send_item(make_item(30000, 20000, -1, -30000, -20000, 3), 0);
            send_item(make_item(3, 4, 0, -3, -4, 0), 0);
            repeat (40) send_item(random_item(), 1);
        end
    endtask

    task automatic test_random_stream;
        write_shift(qftv_pkg::SHIFT_RESET);
        repeat (700) send_item(random_item(), 1);
        write_shift(6'($urandom_range(0, 40)));
        repeat (550) send_item(random_item(), $urandom_range(0, 1));
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_corners();
        test_shift_settings();
        test_random_stream();
        drain_pipeline();
        if (mismatch_count == 0 && quat_queue.size() == 0 && !timed_out)
            $display("quaternion_from_two_vectors_unit verification clean");
        else
            $display("quaternion_from_two_vectors_unit verification failed");
        $finish;
    end

    initial begin
        #2_000_000;
        timed_out = 1'b1;
        $display("quaternion_from_two_vectors_unit verification failed");
        $finish;
    end
endmodule
